// ===== sv/gle_pkg.sv =====
// ----------------------------------------------------------------------------
// gle_pkg
// Shared types and constants of the GIF LZW encoder.
// ----------------------------------------------------------------------------
package gle_pkg;

	localparam int CodeLimitDef     = 4095;
	localparam int SubblockBytesDef = 255;
	localparam int DictDepth        = 4096;

	localparam logic [11:0] NoCode     = 12'hFFF;
	localparam logic [12:0] NoPattern  = 13'h1FFF;
	localparam logic [11:0] ClearCode  = 12'd256;
	localparam logic [11:0] EndCode    = 12'd257;
	localparam logic [11:0] FirstFree  = 12'd258;
	localparam logic [3:0]  StartWidth = 4'd9;
	localparam logic [3:0]  MaxWidth   = 4'd12;

	// input word
	typedef struct packed {
		logic [7:0] pixel;
		logic       last_pixel;
	} pix_word_t;

	// output word
	typedef struct packed {
		logic [7:0] out_byte;
		logic       subblock_end;
		logic       run_last;
		logic       stream_end;
	} byte_word_t;

	// one dictionary entry: node fields of a code plus the root of its suffix tree
	typedef struct packed {
		logic [7:0]  suffix;
		logic [11:0] less;
		logic [11:0] greater;
		logic [11:0] root;
	} entry_t;

	// command from the sequencer to the bit packer
	typedef struct packed {
		logic        put;
		logic [11:0] code;
		logic [3:0]  width;
		logic        flush;
		logic        finish;
		logic        last;
	} pk_cmd_t;

	typedef struct packed {
		logic idle;
	} pk_sts_t;

endpackage

// ===== sv/gle_stream_if.sv =====
// ----------------------------------------------------------------------------
// gle_stream_if
// Valid/ready channel carrying one word per handshake.
// ----------------------------------------------------------------------------
interface gle_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/gle_ram.sv =====
// ----------------------------------------------------------------------------
// gle_ram
// Single-port synchronous RAM, registered read, read-before-write.
// ----------------------------------------------------------------------------
module gle_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ===== sv/gle_packer.sv =====
// ----------------------------------------------------------------------------
// gle_packer
// Packs codes LSB first into bytes, counts sub-blocks, and holds one byte back
// so the end-of-item flags can be set on the final byte of each input word.
// ----------------------------------------------------------------------------
module gle_packer #(
	parameter int SUBBLOCK_BYTES = gle_pkg::SubblockBytesDef
) (
	input  logic             clk,
	input  logic             arst_n,
	input  gle_pkg::pk_cmd_t cmd,
	output gle_pkg::pk_sts_t sts,
	gle_stream_if.source     bytes
);
	logic [23:0]         acc_q;
	logic [4:0]          cnt_q;
	logic                flush_q;
	logic                fin_q;
	logic                fin_last_q;
	logic                pend_v_q;
	logic [7:0]          pend_byte_q;
	logic                pend_close_q;
	logic [7:0]          sub_cnt_q;
	logic                out_v_q;
	gle_pkg::byte_word_t out_q;

	logic        out_free;
	logic        drain_need;
	logic        do_drain;
	logic        do_fin;
	logic [12:0] mask;
	logic [11:0] masked;
	logic [8:0]  sub_next;
	logic        closes;

	// masking and byte-close decision
	assign mask       = (13'd1 << cmd.width) - 13'd1;
	assign masked     = 12'({1'b0, cmd.code} & mask);
	assign out_free   = !out_v_q || bytes.ready;
	assign drain_need = (cnt_q >= 5'd8) || (flush_q && (cnt_q != 5'd0));
	assign do_drain   = drain_need && out_free;
	assign do_fin     = fin_q && (!pend_v_q || out_free);
	assign sub_next   = {1'b0, sub_cnt_q} + 9'd1;
	assign closes     = sub_next >= 9'(SUBBLOCK_BYTES);

	assign sts.idle    = !drain_need && !fin_q;
	assign bytes.valid = out_v_q;
	assign bytes.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			cnt_q        <= '0;
			flush_q      <= 1'b0;
			fin_q        <= 1'b0;
			fin_last_q   <= 1'b0;
			pend_v_q     <= 1'b0;
			pend_byte_q  <= '0;
			pend_close_q <= 1'b0;
			sub_cnt_q    <= '0;
			out_v_q      <= 1'b0;
			out_q        <= '0;
		end else begin
			if (out_v_q && bytes.ready) begin
				out_v_q <= 1'b0;
			end
			// new code into the accumulator
			if (cmd.put) begin
				acc_q <= acc_q | (24'(masked) << cnt_q);
				cnt_q <= cnt_q + 5'(cmd.width);
				if (cmd.flush) begin
					flush_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				fin_q      <= 1'b1;
				fin_last_q <= cmd.last;
			end
			// one byte per cycle while the output register is free; the held byte moves on to the output
			if (do_drain) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
					out_q   <= '{out_byte: pend_byte_q, subblock_end: pend_close_q,
						run_last: 1'b0, stream_end: 1'b0};
				end
				pend_v_q     <= 1'b1;
				pend_byte_q  <= acc_q[7:0];
				pend_close_q <= closes;
				sub_cnt_q    <= closes ? 8'd0 : sub_next[7:0];
				acc_q        <= acc_q >> 8;
				cnt_q        <= (cnt_q >= 5'd8) ? cnt_q - 5'd8 : 5'd0;
			end
			// end of item: release held byte with the run flags
			if (do_fin) begin
				if (pend_v_q) begin
					out_v_q <= 1'b1;
					out_q   <= '{out_byte: pend_byte_q,
						subblock_end: pend_close_q | fin_last_q,
						run_last: 1'b1, stream_end: fin_last_q};
				end
				pend_v_q <= 1'b0;
				fin_q    <= 1'b0;
				if (fin_last_q) begin
					sub_cnt_q <= '0;
					acc_q     <= '0;
					cnt_q     <= '0;
					flush_q   <= 1'b0;
				end
			end
		end
	end
endmodule

// ===== sv/gif_lzw_encoder.sv =====
// ----------------------------------------------------------------------------
// gif_lzw_encoder
// GIF LZW encoder for 8-bit pixels with a tree dictionary in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   pixels carries one pixel word (pixel, last_pixel) per handshake; bytes
//   carries packed code bytes with sub-block, run and stream end flags.
//   One pixel is worked on at a time. For a pixel whose pattern extends,
//   every suffix tree level walked is one read of the dictionary RAM. A
//   pixel that ends a pattern also packs its code into one or two bytes,
//   and the new code adds 2 RAM writes. Tree depth depends on the data.
//   The first pixel of a stream adds the clear code, the final pixel adds
//   three codes and a flush of up to 5 bytes.
//   The last byte of a pixel leaves through a one-word output register, so
//   the next pixel is taken while that byte still waits for the receiver.
//   A stalled receiver holds the block in its byte emission steps.
//   Reset: the per-byte root valid bits clear at once, no clearing pass;
//   tree roots of new codes are written when the code is assigned. The first
//   pixel after reset or after a last pixel starts a stream with a clear code.
// ----------------------------------------------------------------------------
module gif_lzw_encoder #(
	parameter int CODE_LIMIT     = gle_pkg::CodeLimitDef,
	parameter int SUBBLOCK_BYTES = gle_pkg::SubblockBytesDef
) (
	input logic          clk,
	input logic          arst_n,
	gle_stream_if.sink   pixels,
	gle_stream_if.source bytes
);
	localparam int AddrW = $clog2(gle_pkg::DictDepth);

	typedef enum logic [3:0] {
		ST_IDLE, ST_START, ST_TAKE, ST_ROOT, ST_NODE, ST_MISS, ST_ADD,
		ST_LINK, ST_SETPX, ST_LAST, ST_LCLR, ST_LEND, ST_FIN, ST_WAIT
	} state_t;

	typedef enum logic [1:0] {SK_ROOT, SK_LESS, SK_GREATER} slot_kind_t;

	state_t           state_q, ret_q;
	logic [7:0]       px_q;
	logic             last_q;
	logic             started_q;
	logic [12:0]      cur_q;
	logic [11:0]      nfc_q;
	logic [3:0]       width_q;
	logic [11:0]      nc_q;
	gle_pkg::entry_t  held_q;
	logic [11:0]      slot_addr_q;
	slot_kind_t       slot_kind_q;
	logic [11:0]      node_q;
	logic [255:0]     vld_q;

	logic             ram_we;
	logic [AddrW-1:0] ram_addr;
	gle_pkg::entry_t  ram_wdata, ram_rdata, link_word;
	gle_pkg::pk_cmd_t cmd;
	gle_pkg::pk_sts_t sts;

	logic [11:0] root_code;
	logic        cur_is_byte;
	logic        hit;
	logic        go_less;
	logic [11:0] next_link;
	logic        dict_room;

	assign cur_is_byte = (cur_q[12:8] == 5'd0);
	assign root_code   = (cur_is_byte && !vld_q[cur_q[7:0]]) ? gle_pkg::NoCode
		: ram_rdata.root;
	assign hit         = (ram_rdata.suffix == px_q);
	assign go_less     = (ram_rdata.suffix > px_q);
	assign next_link   = go_less ? ram_rdata.less : ram_rdata.greater;
	assign dict_room   = (nfc_q < 12'(CODE_LIMIT));
	assign pixels.ready = (state_q == ST_IDLE);

	// slot update word: the read entry with one link replaced by the new code
	always_comb begin
		link_word = held_q;
		case (slot_kind_q)
			SK_ROOT:    link_word.root    = nc_q;
			SK_LESS:    link_word.less    = nc_q;
			SK_GREATER: link_word.greater = nc_q;
			default:    link_word.root    = nc_q;
		endcase
	end

	// RAM port
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = cur_q[AddrW-1:0];
		ram_wdata = link_word;
		case (state_q)
			ST_ROOT: ram_addr = root_code[AddrW-1:0];
			ST_NODE: ram_addr = next_link[AddrW-1:0];
			ST_ADD: begin
				ram_addr  = nfc_q[AddrW-1:0];
				ram_we    = dict_room;
				ram_wdata = '{suffix: px_q, less: gle_pkg::NoCode,
					greater: gle_pkg::NoCode, root: gle_pkg::NoCode};
			end
			ST_LINK: begin
				ram_addr = slot_addr_q[AddrW-1:0];
				ram_we   = 1'b1;
			end
			default: ram_addr = cur_q[AddrW-1:0];
		endcase
	end

	// packer commands
	always_comb begin
		cmd = '0;
		cmd.width = width_q;
		case (state_q)
			ST_START, ST_LCLR: begin
				cmd.put  = 1'b1;
				cmd.code = gle_pkg::ClearCode;
			end
			ST_ADD: begin
				cmd.put  = !dict_room;
				cmd.code = gle_pkg::ClearCode;
			end
			ST_MISS: begin
				cmd.put  = 1'b1;
				cmd.code = cur_q[11:0];
			end
			ST_LAST: begin
				cmd.put  = last_q;
				cmd.code = cur_q[11:0];
			end
			ST_LEND: begin
				cmd.put   = 1'b1;
				cmd.code  = gle_pkg::EndCode;
				cmd.width = gle_pkg::StartWidth;
				cmd.flush = 1'b1;
			end
			ST_FIN: begin
				cmd.finish = 1'b1;
				cmd.last   = last_q;
			end
			default: cmd.put = 1'b0;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ret_q       <= ST_IDLE;
			px_q        <= '0;
			last_q      <= 1'b0;
			started_q   <= 1'b0;
			cur_q       <= gle_pkg::NoPattern;
			nfc_q       <= gle_pkg::FirstFree;
			width_q     <= gle_pkg::StartWidth;
			nc_q        <= '0;
			held_q      <= '0;
			slot_addr_q <= '0;
			slot_kind_q <= SK_ROOT;
			node_q      <= '0;
			vld_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pixels.valid) begin
						px_q    <= pixels.data.pixel;
						last_q  <= pixels.data.last_pixel;
						state_q <= started_q ? ST_TAKE : ST_START;
					end
				end
				ST_START: begin
					started_q <= 1'b1;
					width_q   <= gle_pkg::StartWidth;
					nfc_q     <= gle_pkg::FirstFree;
					cur_q     <= gle_pkg::NoPattern;
					vld_q     <= '0;
					ret_q     <= ST_TAKE;
					state_q   <= ST_WAIT;
				end
				ST_TAKE: begin
					if (cur_q == gle_pkg::NoPattern) begin
						cur_q   <= {5'd0, px_q};
						state_q <= ST_LAST;
					end else begin
						state_q <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					held_q      <= ram_rdata;
					slot_addr_q <= cur_q[11:0];
					slot_kind_q <= SK_ROOT;
					node_q      <= root_code;
					state_q     <= (root_code == gle_pkg::NoCode) ? ST_MISS : ST_NODE;
				end
				// ram_rdata is the node whose code is node_q
				ST_NODE: begin
					if (hit) begin
						cur_q   <= {1'b0, node_q};
						state_q <= ST_LAST;
					end else begin
						held_q      <= ram_rdata;
						slot_addr_q <= node_q;
						slot_kind_q <= go_less ? SK_LESS : SK_GREATER;
						node_q      <= next_link;
						state_q     <= (next_link == gle_pkg::NoCode) ? ST_MISS : ST_NODE;
					end
				end
				ST_MISS: begin
					ret_q   <= ST_ADD;
					state_q <= ST_WAIT;
				end
				ST_ADD: begin
					if (dict_room) begin
						nc_q  <= nfc_q;
						nfc_q <= nfc_q + 12'd1;
						if (({1'b0, nfc_q} >= (13'd1 << width_q))
							&& (width_q < gle_pkg::MaxWidth)) begin
							width_q <= width_q + 4'd1;
						end
						state_q <= ST_LINK;
					end else begin
						width_q <= gle_pkg::StartWidth;
						nfc_q   <= gle_pkg::FirstFree;
						vld_q   <= '0;
						ret_q   <= ST_SETPX;
						state_q <= ST_WAIT;
					end
				end
				ST_LINK: begin
					if (slot_kind_q == SK_ROOT && cur_is_byte) begin
						vld_q[cur_q[7:0]] <= 1'b1;
					end
					state_q <= ST_SETPX;
				end
				ST_SETPX: begin
					cur_q   <= {5'd0, px_q};
					state_q <= ST_LAST;
				end
				ST_LAST: begin
					if (last_q) begin
						ret_q   <= ST_LCLR;
						state_q <= ST_WAIT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_LCLR: begin
					width_q <= gle_pkg::StartWidth;
					nfc_q   <= gle_pkg::FirstFree;
					cur_q   <= gle_pkg::NoPattern;
					vld_q   <= '0;
					ret_q   <= ST_LEND;
					state_q <= ST_WAIT;
				end
				ST_LEND: begin
					ret_q   <= ST_FIN;
					state_q <= ST_WAIT;
				end
				ST_FIN: begin
					if (last_q) begin
						started_q <= 1'b0;
					end
					ret_q   <= ST_IDLE;
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (sts.idle) begin
						state_q <= ret_q;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	gle_ram #(
		.Width($bits(gle_pkg::entry_t)),
		.Depth(gle_pkg::DictDepth)
	) u_dict (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	gle_packer #(
		.SUBBLOCK_BYTES(SUBBLOCK_BYTES)
	) u_packer (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cmd),
		.sts   (sts),
		.bytes (bytes)
	);
endmodule

// ===== sv/gle_checker.sv =====
// ----------------------------------------------------------------------------
// gle_checker
// Port-level checks of the GIF LZW encoder, bound to the top level.
// ----------------------------------------------------------------------------
module gle_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input gle_pkg::byte_word_t out_data
);
	// a stalled output word is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	// the stream end byte also ends its run and its sub-block
	a_end_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stream_end |-> out_data.run_last && out_data.subblock_end)
		else $error("stream end without run or sub-block end");

	// one pixel at a time: no word is taken right after an accepted one
	a_one_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel accepted back to back");

	// outputs idle right after reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("output valid out of reset");
endmodule

bind gif_lzw_encoder gle_checker u_gle_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (pixels.valid),
	.in_ready (pixels.ready),
	.out_valid(bytes.valid),
	.out_ready(bytes.ready),
	.out_data (bytes.data)
);
